### hw/rtl/svpwm_dc_pkg.sv
`default_nettype none

package svpwm_dc_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;

	// Q.30 times, their sum and the divider remainder
	localparam int T_W    = 31;
	localparam int SUM_W  = 32;
	localparam int REM_W  = 33;
	localparam int DUTY_W = 16;

	localparam logic [16:0]        SQRT3_HALF_Q16 = 17'd56756;
	localparam logic [SUM_W-1:0]   Q30_ONE        = 32'h4000_0000;
	localparam logic [SUM_W-1:0]   Q15_RND        = 32'h0000_8000;
	localparam logic [DUTY_W-1:0]  DUTY_FULL      = 16'h8000;
	localparam logic [DUTY_W-1:0]  DUTY_HALF      = 16'h4000;

	// sign code {Y<0, Z<0, X>0}
	typedef enum logic [2:0] {
		SEC_ZERO = 3'd0,
		SEC_C1   = 3'd1,
		SEC_C2   = 3'd2,
		SEC_C3   = 3'd3,
		SEC_C4   = 3'd4,
		SEC_C5   = 3'd5,
		SEC_C6   = 3'd6,
		SEC_ALL  = 3'd7
	} sector_t;

	typedef struct packed {
		logic             over;
		sector_t          sec;
		logic [T_W-1:0]   t1;
		logic [T_W-1:0]   t2;
	} div_side_t;

endpackage

`default_nettype wire

### hw/rtl/svpwm_dc_div.sv
`default_nettype none

module svpwm_dc_div
	import svpwm_dc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [T_W-1:0]    dvd_a,
	input  wire logic [T_W-1:0]    dvd_b,
	input  wire logic [SUM_W-1:0]  dvs,
	input  wire div_side_t         side_i,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [T_W-1:0]         quo_a,
	output logic [T_W-1:0]         quo_b,
	output div_side_t              side_o
);

	// one quotient bit per stage, MSB (weight 2^30) first
	localparam int STEPS = T_W;

	logic [STEPS-1:0]  v_s;
	logic [STEPS-1:0]  en;
	logic [STEPS-1:0]  v_pv;

	logic [REM_W-1:0]  rema_s [STEPS];
	logic [REM_W-1:0]  remb_s [STEPS];
	logic [T_W-1:0]    qa_s   [STEPS];
	logic [T_W-1:0]    qb_s   [STEPS];
	logic [SUM_W-1:0]  dvs_s  [STEPS];
	div_side_t         side_s [STEPS];

	logic [REM_W-1:0]  rema_pv [STEPS];
	logic [REM_W-1:0]  remb_pv [STEPS];
	logic [T_W-1:0]    qa_pv   [STEPS];
	logic [T_W-1:0]    qb_pv   [STEPS];
	logic [SUM_W-1:0]  dvs_pv  [STEPS];
	div_side_t         side_pv [STEPS];

	logic [REM_W-1:0]  rema_nx [STEPS];
	logic [REM_W-1:0]  remb_nx [STEPS];
	logic [T_W-1:0]    qa_nx   [STEPS];
	logic [T_W-1:0]    qb_nx   [STEPS];

	always_comb begin
		v_pv[0]    = in_valid;
		rema_pv[0] = {2'b00, dvd_a};
		remb_pv[0] = {2'b00, dvd_b};
		qa_pv[0]   = '0;
		qb_pv[0]   = '0;
		dvs_pv[0]  = dvs;
		side_pv[0] = side_i;
		for (int k = 1; k < STEPS; k++) begin
			v_pv[k]    = v_s[k-1];
			rema_pv[k] = rema_s[k-1];
			remb_pv[k] = remb_s[k-1];
			qa_pv[k]   = qa_s[k-1];
			qb_pv[k]   = qb_s[k-1];
			dvs_pv[k]  = dvs_s[k-1];
			side_pv[k] = side_s[k-1];
		end
	end

	always_comb begin
		logic [REM_W-1:0] dv;
		logic             ge_a;
		logic             ge_b;
		logic [REM_W-1:0] da;
		logic [REM_W-1:0] db;
		for (int k = 0; k < STEPS; k++) begin
			dv         = {1'b0, dvs_pv[k]};
			ge_a       = rema_pv[k] >= dv;
			ge_b       = remb_pv[k] >= dv;
			da         = ge_a ? (rema_pv[k] - dv) : rema_pv[k];
			db         = ge_b ? (remb_pv[k] - dv) : remb_pv[k];
			rema_nx[k] = {da[REM_W-2:0], 1'b0};
			remb_nx[k] = {db[REM_W-2:0], 1'b0};
			qa_nx[k]   = {qa_pv[k][T_W-2:0], ge_a};
			qb_nx[k]   = {qb_pv[k][T_W-2:0], ge_b};
		end
	end

	// a stage loads when empty or when the next one moves
	generate
		for (genvar g = 0; g < STEPS - 1; g++) begin : g_en
			assign en[g] = ~v_s[g] | en[g+1];
		end
	endgenerate
	assign en[STEPS-1] = ~v_s[STEPS-1] | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k < STEPS; k++) begin
				if (en[k]) begin
					v_s[k] <= v_pv[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < STEPS; k++) begin
			if (en[k]) begin
				rema_s[k] <= rema_nx[k];
				remb_s[k] <= remb_nx[k];
				qa_s[k]   <= qa_nx[k];
				qb_s[k]   <= qb_nx[k];
				dvs_s[k]  <= dvs_pv[k];
				side_s[k] <= side_pv[k];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[STEPS-1];
	assign quo_a     = qa_s[STEPS-1];
	assign quo_b     = qb_s[STEPS-1];
	assign side_o    = side_s[STEPS-1];

endmodule

`default_nettype wire

### hw/rtl/svpwm_duty_calculator_core.sv
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    alpha_cmd, beta_cmd
// out      out_valid / out_ready  sector_code, duty_phase_a, duty_phase_b, duty_phase_c
//
// One transaction per cycle sustained while out_ready stays high.
// Front: multiply, projections, sector select with Q.30 scaling, time sum (4 stages).
// Clamp divider: 31 stages, one quotient bit each; back end: 2 stages.
// Reset clears the valid bits only.
// A stalled stage holds; empty stages still fill, so input is taken while a result waits.

module svpwm_duty_calculator_core
	import svpwm_dc_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  alpha_cmd,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  beta_cmd,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [2:0]                           sector_code,
	output logic [DUTY_W-1:0]                    duty_phase_a,
	output logic [DUTY_W-1:0]                    duty_phase_b,
	output logic [DUTY_W-1:0]                    duty_phase_c
);

	localparam int PW     = SAMPLE_WIDTH + 18;
	localparam int SH     = SAMPLE_WIDTH - 15;
	localparam int RSHIFT = (SH > 0) ? SH : 0;
	localparam int LSHIFT = (SH > 0) ? 0 : -SH;
	localparam int RPOS   = (SH > 0) ? SH - 1 : 0;
	localparam logic [PW+15:0] RND = (SH > 0) ? ((PW+16)'(1) << RPOS) : '0;

	function automatic logic [T_W-1:0] to_q30(input logic signed [PW-1:0] r);
		logic [PW+15:0] ext;
		logic [PW+15:0] sc;
		ext = r[PW-1] ? '0 : {16'b0, r};
		sc  = ((ext + RND) >> RSHIFT) << LSHIFT;
		return sc[T_W-1:0];
	endfunction

	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// s1: alpha * sqrt3/2
	logic signed [PW-1:0]            mult;
	logic signed [PW-1:0]            prod_s1;
	logic signed [SAMPLE_WIDTH-1:0]  be_s1;

	assign mult = alpha_cmd * $signed({1'b0, SQRT3_HALF_Q16});

	// s2: X, Y, Z and negations
	logic signed [PW-1:0] be_h, x_c, y_c, z_c;
	logic signed [PW-1:0] x_s2, nx_s2, y_s2, ny_s2, z_s2, nz_s2;
	sector_t              sec_c, sec_s2;

	assign be_h  = {{3{be_s1[SAMPLE_WIDTH-1]}}, be_s1, 15'b0};
	assign x_c   = {{2{be_s1[SAMPLE_WIDTH-1]}}, be_s1, 16'b0};
	assign y_c   = prod_s1 + be_h;
	assign z_c   = be_h - prod_s1;
	assign sec_c = sector_t'({y_c[PW-1], z_c[PW-1],
		~be_s1[SAMPLE_WIDTH-1] & (be_s1 != '0)});

	// s3: active vector times in Q.30
	logic signed [PW-1:0] r1_c, r2_c;
	logic [T_W-1:0]       t1_s3, t2_s3;
	sector_t              sec_s3;

	always_comb begin
		unique case (sec_s2)
			SEC_C3: begin r1_c = nz_s2; r2_c = x_s2;  end
			SEC_C1: begin r1_c = z_s2;  r2_c = y_s2;  end
			SEC_C5: begin r1_c = x_s2;  r2_c = ny_s2; end
			SEC_C4: begin r1_c = nx_s2; r2_c = z_s2;  end
			SEC_C6: begin r1_c = ny_s2; r2_c = nz_s2; end
			SEC_C2: begin r1_c = y_s2;  r2_c = nx_s2; end
			default: begin r1_c = '0;   r2_c = '0;    end
		endcase
	end

	// s4: sum and clamp decision
	logic [SUM_W-1:0] sum_c, sum_s4;
	logic             over_s4;
	logic [T_W-1:0]   t1_s4, t2_s4;
	sector_t          sec_s4;

	assign sum_c = SUM_W'(t1_s3) + SUM_W'(t2_s3);

	// divider
	logic            div_in_ready, div_out_valid;
	logic [T_W-1:0]  quo_a, quo_b;
	div_side_t       side_in, side_out;

	assign side_in = '{over: over_s4, sec: sec_s4, t1: t1_s4, t2: t2_s4};

	svpwm_dc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.dvd_a     (t1_s4),
		.dvd_b     (t2_s4),
		.dvs       (sum_s4),
		.side_i    (side_in),
		.out_valid (div_out_valid),
		.out_ready (en_s5),
		.quo_a     (quo_a),
		.quo_b     (quo_b),
		.side_o    (side_out)
	);

	// s5: clamped times
	logic [T_W-1:0] t1_s5, t2_s5;
	sector_t        sec_s5;

	// s6: duties, permuted to phases
	logic [SUM_W-1:0]  dh_w, dm_w, dl_w;
	logic [DUTY_W-1:0] dh, dm, dl;
	logic [DUTY_W-1:0] da_c, db_c, dc_c;
	logic [DUTY_W-1:0] da_s6, db_s6, dc_s6;
	sector_t           sec_s6;

	assign dh_w = Q30_ONE + SUM_W'(t1_s5) + SUM_W'(t2_s5) + Q15_RND;
	assign dm_w = Q30_ONE - SUM_W'(t1_s5) + SUM_W'(t2_s5) + Q15_RND;
	assign dl_w = Q30_ONE - SUM_W'(t1_s5) - SUM_W'(t2_s5) + Q15_RND;
	assign dh   = dh_w[SUM_W-1:16];
	assign dm   = dm_w[SUM_W-1:16];
	assign dl   = dl_w[SUM_W-1:16];

	always_comb begin
		unique case (sec_s5)
			SEC_C3:  begin da_c = dh; db_c = dm; dc_c = dl; end
			SEC_C1:  begin da_c = dm; db_c = dh; dc_c = dl; end
			SEC_C5:  begin da_c = dl; db_c = dh; dc_c = dm; end
			SEC_C4:  begin da_c = dl; db_c = dm; dc_c = dh; end
			SEC_C6:  begin da_c = dm; db_c = dl; dc_c = dh; end
			default: begin da_c = dh; db_c = dl; dc_c = dm; end
		endcase
	end

	// stall chain
	assign en_s6 = ~v_s6 | out_ready;
	assign en_s5 = ~v_s5 | en_s6;
	assign en_s4 = ~v_s4 | div_in_ready;
	assign en_s3 = ~v_s3 | en_s4;
	assign en_s2 = ~v_s2 | en_s3;
	assign en_s1 = ~v_s1 | en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= div_out_valid;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= mult;
			be_s1   <= beta_cmd;
		end
		if (en_s2) begin
			x_s2   <= x_c;
			nx_s2  <= -x_c;
			y_s2   <= y_c;
			ny_s2  <= -y_c;
			z_s2   <= z_c;
			nz_s2  <= -z_c;
			sec_s2 <= sec_c;
		end
		if (en_s3) begin
			t1_s3  <= to_q30(r1_c);
			t2_s3  <= to_q30(r2_c);
			sec_s3 <= sec_s2;
		end
		if (en_s4) begin
			sum_s4  <= sum_c;
			over_s4 <= sum_c > Q30_ONE;
			t1_s4   <= t1_s3;
			t2_s4   <= t2_s3;
			sec_s4  <= sec_s3;
		end
		if (en_s5) begin
			t1_s5  <= side_out.over ? quo_a : side_out.t1;
			t2_s5  <= side_out.over ? quo_b : side_out.t2;
			sec_s5 <= side_out.sec;
		end
		if (en_s6) begin
			da_s6  <= da_c;
			db_s6  <= db_c;
			dc_s6  <= dc_c;
			sec_s6 <= sec_s5;
		end
	end

	assign in_ready     = en_s1;
	assign out_valid    = v_s6;
	assign sector_code  = sec_s6;
	assign duty_phase_a = da_s6;
	assign duty_phase_b = db_s6;
	assign duty_phase_c = dc_s6;

`ifndef SYNTHESIS
	a_no_code_seven: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> sec_s2 != SEC_ALL)
		else $error("sector code seven from projections");

	a_clamp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (SUM_W'(t1_s5) + SUM_W'(t2_s5)) <= Q30_ONE)
		else $error("clamped times exceed one");

	a_null_times: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && (sec_s5 == SEC_ZERO || sec_s5 == SEC_ALL) |-> t1_s5 == '0 && t2_s5 == '0)
		else $error("non-zero times for zero vector");

	a_null_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sector_code == SEC_ZERO || sector_code == SEC_ALL) |->
		duty_phase_a == DUTY_HALF && duty_phase_b == DUTY_HALF && duty_phase_c == DUTY_HALF)
		else $error("zero vector duty not half");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		duty_phase_a <= DUTY_FULL && duty_phase_b <= DUTY_FULL && duty_phase_c <= DUTY_FULL)
		else $error("duty above full scale");
`endif

endmodule

`default_nettype wire
